// ===== hdl/sle_pkg.sv =====
// Shared types, sizes and codes for the sequential list engine.
`default_nettype none

package sle_pkg;

  localparam int DEPTH   = 128;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LEN_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int POS_W   = 8;
  localparam int ST_W    = 3;
  localparam int COUNT_W = 8;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  // Read pointer commands
  localparam logic [2:0] PTR_HOLD      = 3'd0;
  localparam logic [2:0] PTR_LOAD_TAIL = 3'd1;
  localparam logic [2:0] PTR_LOAD_POS  = 3'd2;
  localparam logic [2:0] PTR_LOAD_ZERO = 3'd3;
  localparam logic [2:0] PTR_INC       = 3'd4;
  localparam logic [2:0] PTR_DEC       = 3'd5;

  // Store write commands
  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_APPEND = 3'd1;
  localparam logic [2:0] WR_UP     = 3'd2;
  localparam logic [2:0] WR_DOWN   = 3'd3;
  localparam logic [2:0] WR_VALUE  = 3'd4;

  // Length commands
  localparam logic [1:0] LEN_HOLD  = 2'd0;
  localparam logic [1:0] LEN_CLEAR = 2'd1;
  localparam logic [1:0] LEN_INC   = 2'd2;
  localparam logic [1:0] LEN_DEC   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic [COUNT_W-1:0]       found_position;
    logic signed [DATA_W-1:0] removed_value;
    logic [COUNT_W-1:0]       list_count;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       set_chk;
    logic       set_notfound;
    logic       set_found;
    logic       take_removed;
    logic       rd;
    logic       publish;
    logic [2:0] ptr_op;
    logic [2:0] wr_op;
    logic [1:0] len_op;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            chk_fail;
    logic            ptr_at_pos;
    logic            ptr_at_tail;
    logic            prev_at_pos;
    logic            rd_vld;
    logic            match;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/sle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sle_dp.sv =====
// Datapath: request register, list length, read pointer, store and result register.
`default_nettype none

module sle_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sle_pkg::req_t req,
  input  wire sle_pkg::cmd_t cmd,
  output sle_pkg::sts_t      sts,
  output sle_pkg::rsp_t      rsp
);

  sle_pkg::req_t                   req_q;
  logic [sle_pkg::LEN_W-1:0]       len;
  logic [sle_pkg::ADDR_W-1:0]      ptr;
  logic [sle_pkg::ADDR_W-1:0]      prev_ptr;
  logic                            rd_vld;
  logic [sle_pkg::ST_W-1:0]        res_status;
  logic [sle_pkg::COUNT_W-1:0]     res_found;
  logic signed [sle_pkg::DATA_W-1:0] res_removed;
  sle_pkg::rsp_t                   rsp_q;

  logic [sle_pkg::DATA_W-1:0]      rdata;
  logic                            we;
  logic [sle_pkg::ADDR_W-1:0]      waddr;
  logic [sle_pkg::DATA_W-1:0]      wdata;
  logic [sle_pkg::ADDR_W-1:0]      pos_m1;
  logic [sle_pkg::ADDR_W-1:0]      len_m1;
  logic                            full;
  logic                            empty;
  logic                            pos_ok;
  logic [sle_pkg::ST_W-1:0]        chk_status;

  assign pos_m1 = sle_pkg::ADDR_W'(req_q.position - sle_pkg::POS_W'(1));
  assign len_m1 = sle_pkg::ADDR_W'(len - sle_pkg::LEN_W'(1));
  assign full   = (32'(len) >= 32'(sle_pkg::DEPTH));
  assign empty  = (len == '0);
  assign pos_ok = (req_q.position != '0) && (32'(req_q.position) <= 32'(len));

  // Checks on the latched request against the current length
  always_comb begin
    chk_status = sle_pkg::ST_OK;
    unique case (req_q.opcode)
      sle_pkg::OP_APPEND: begin
        if (full) chk_status = sle_pkg::ST_FULL;
      end
      sle_pkg::OP_INSERT: begin
        if (full) chk_status = sle_pkg::ST_FULL;
        else if (!pos_ok) chk_status = sle_pkg::ST_BADPOS;
      end
      sle_pkg::OP_DELETE: begin
        if (empty) chk_status = sle_pkg::ST_EMPTY;
        else if (!pos_ok) chk_status = sle_pkg::ST_BADPOS;
      end
      sle_pkg::OP_FIND: begin
        if (empty) chk_status = sle_pkg::ST_EMPTY;
      end
      default: chk_status = sle_pkg::ST_OK;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    unique case (cmd.wr_op)
      sle_pkg::WR_APPEND: begin
        we    = 1'b1;
        waddr = sle_pkg::ADDR_W'(len);
        wdata = req_q.value;
      end
      sle_pkg::WR_UP: begin
        we    = 1'b1;
        waddr = prev_ptr + sle_pkg::ADDR_W'(1);
      end
      sle_pkg::WR_DOWN: begin
        we    = 1'b1;
        waddr = prev_ptr - sle_pkg::ADDR_W'(1);
      end
      sle_pkg::WR_VALUE: begin
        we    = 1'b1;
        waddr = pos_m1;
        wdata = req_q.value;
      end
      default: we = 1'b0;
    endcase
  end

  sle_ram #(
    .WIDTH(sle_pkg::DATA_W),
    .DEPTH(sle_pkg::DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd),
    .raddr(ptr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd;
      unique case (cmd.len_op)
        sle_pkg::LEN_CLEAR: len <= '0;
        sle_pkg::LEN_INC:   len <= len + sle_pkg::LEN_W'(1);
        sle_pkg::LEN_DEC:   len <= len - sle_pkg::LEN_W'(1);
        default:            len <= len;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q       <= req;
      res_status  <= sle_pkg::ST_OK;
      res_found   <= '0;
      res_removed <= '0;
    end else begin
      if (cmd.set_chk) res_status <= chk_status;
      if (cmd.set_notfound) res_status <= sle_pkg::ST_NOTFOUND;
      if (cmd.set_found) begin
        res_found <= sle_pkg::COUNT_W'(32'(prev_ptr) + 32'd1);
      end
      if (cmd.take_removed) res_removed <= $signed(rdata);
    end
    if (cmd.rd) prev_ptr <= ptr;
    unique case (cmd.ptr_op)
      sle_pkg::PTR_LOAD_TAIL: ptr <= len_m1;
      sle_pkg::PTR_LOAD_POS:  ptr <= pos_m1;
      sle_pkg::PTR_LOAD_ZERO: ptr <= '0;
      sle_pkg::PTR_INC:       ptr <= ptr + sle_pkg::ADDR_W'(1);
      sle_pkg::PTR_DEC:       ptr <= ptr - sle_pkg::ADDR_W'(1);
      default:                ptr <= ptr;
    endcase
    if (cmd.publish) begin
      rsp_q <= '{status:         res_status,
                 found_position: res_found,
                 removed_value:  res_removed,
                 list_count:     sle_pkg::COUNT_W'(len)};
    end
  end

  assign sts.opcode      = req_q.opcode;
  assign sts.chk_fail    = (chk_status != sle_pkg::ST_OK);
  assign sts.ptr_at_pos  = (ptr == pos_m1);
  assign sts.ptr_at_tail = (ptr == len_m1);
  assign sts.prev_at_pos = (prev_ptr == pos_m1);
  assign sts.rd_vld      = rd_vld;
  assign sts.match       = rd_vld && (rdata == req_q.value);
  assign rsp             = rsp_q;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(len) <= 32'(sle_pkg::DEPTH))
    else $error("list length above store depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && cmd.rd) |-> (waddr != ptr))
    else $error("store read and write at the same address");

  a_found_only_find: assert property (@(posedge clk) disable iff (rst)
    cmd.set_found |-> (req_q.opcode == sle_pkg::OP_FIND))
    else $error("found position set outside a find");

endmodule

`default_nettype wire

// ===== hdl/sle_ctrl.sv =====
// Controller state machine: sequences store reads and writes for each request.
`default_nettype none

module sle_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  input  wire sle_pkg::sts_t sts,
  output sle_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_INS_RD    = 4'd2;
  localparam logic [3:0] S_INS_WB    = 4'd3;
  localparam logic [3:0] S_INS_PUT   = 4'd4;
  localparam logic [3:0] S_DEL_RD    = 4'd5;
  localparam logic [3:0] S_DEL_WB    = 4'd6;
  localparam logic [3:0] S_FIND_RD   = 4'd7;
  localparam logic [3:0] S_FIND_LAST = 4'd8;
  localparam logic [3:0] S_FINISH    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        if (sts.chk_fail) begin
          cmd.set_chk = 1'b1;
        end else begin
          unique case (sts.opcode)
            sle_pkg::OP_CLEAR: cmd.len_op = sle_pkg::LEN_CLEAR;
            sle_pkg::OP_APPEND: begin
              cmd.wr_op  = sle_pkg::WR_APPEND;
              cmd.len_op = sle_pkg::LEN_INC;
            end
            sle_pkg::OP_INSERT: begin
              cmd.ptr_op = sle_pkg::PTR_LOAD_TAIL;
              state_next = S_INS_RD;
            end
            sle_pkg::OP_DELETE: begin
              cmd.ptr_op = sle_pkg::PTR_LOAD_POS;
              state_next = S_DEL_RD;
            end
            sle_pkg::OP_FIND: begin
              cmd.ptr_op = sle_pkg::PTR_LOAD_ZERO;
              state_next = S_FIND_RD;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_INS_RD: begin
        // walk down from the tail, each entry moves up one place
        cmd.rd = 1'b1;
        if (sts.rd_vld) cmd.wr_op = sle_pkg::WR_UP;
        if (sts.ptr_at_pos) state_next = S_INS_WB;
        else cmd.ptr_op = sle_pkg::PTR_DEC;
      end
      S_INS_WB: begin
        cmd.wr_op  = sle_pkg::WR_UP;
        state_next = S_INS_PUT;
      end
      S_INS_PUT: begin
        cmd.wr_op  = sle_pkg::WR_VALUE;
        cmd.len_op = sle_pkg::LEN_INC;
        state_next = S_FINISH;
      end
      S_DEL_RD: begin
        // first entry back is the removed one, later ones move down
        cmd.rd = 1'b1;
        if (sts.rd_vld) begin
          if (sts.prev_at_pos) cmd.take_removed = 1'b1;
          else cmd.wr_op = sle_pkg::WR_DOWN;
        end
        if (sts.ptr_at_tail) state_next = S_DEL_WB;
        else cmd.ptr_op = sle_pkg::PTR_INC;
      end
      S_DEL_WB: begin
        if (sts.prev_at_pos) cmd.take_removed = 1'b1;
        else cmd.wr_op = sle_pkg::WR_DOWN;
        cmd.len_op = sle_pkg::LEN_DEC;
        state_next = S_FINISH;
      end
      S_FIND_RD: begin
        if (sts.match) begin
          cmd.set_found = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.rd = 1'b1;
          if (sts.ptr_at_tail) state_next = S_FIND_LAST;
          else cmd.ptr_op = sle_pkg::PTR_INC;
        end
      end
      S_FIND_LAST: begin
        if (sts.match) cmd.set_found = 1'b1;
        else cmd.set_notfound = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  a_ins_wb_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WB) |-> sts.rd_vld)
    else $error("insert write-back without read data");

  a_del_wb_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEL_WB) |-> sts.rd_vld)
    else $error("delete write-back without read data");

  a_find_last_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND_LAST) |-> sts.rd_vld)
    else $error("last find compare without read data");

endmodule

`default_nettype wire

// ===== hdl/sequential_list_engine.sv =====
// Top level: ordered list of signed values with append, insert, delete and find.
// Clear, append, unused opcodes and failed checks finish in the decode state, then the result is published.
// Insert and delete move each entry from the position to the tail; find reads from the head until
// a match or the tail, one store access per cycle on the single read port.
// One transaction at a time; the next is accepted while a result waits in the output register.
// Reset clears length and output valid; store contents stay undefined, no clearing pass.
`default_nettype none

module sequential_list_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire sle_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output sle_pkg::rsp_t      rsp
);

  sle_pkg::cmd_t cmd;
  sle_pkg::sts_t sts;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sle_dp u_dp (
    .clk(clk),
    .rst(rst),
    .req(req),
    .cmd(cmd),
    .sts(sts),
    .rsp(rsp)
  );

endmodule

`default_nettype wire
